// ----- rtl/hnrs_pkg.sv -----
// ---------------------------------------------------------------------------
// hnrs_pkg: shared types and constants for the hex port selector
// Request and result structs, opcodes, angle classes and the lane candidate.
// ---------------------------------------------------------------------------
package hnrs_pkg;

  localparam int NUM_PORTS  = 6;
  localparam int COORD_BITS = 8;
  localparam int PACK_W     = NUM_PORTS * COORD_BITS;
  localparam int PORT_W     = 3;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MUL_W      = 2 * DIFF_W;
  localparam int DOT_W      = MUL_W + 1;
  localparam int XPROD_W    = 2 * DOT_W;

  // Opcodes
  localparam logic [1:0] OP_ANGLE = 2'd0;
  localparam logic [1:0] OP_CCW   = 2'd1;
  localparam logic [1:0] OP_CW    = 2'd2;

  // Angle classes, ordered from smallest to largest angle
  typedef enum logic [1:0] {
    CLS_LOW  = 2'd0,   // det < 0, angle in (0,180)
    CLS_HALF = 2'd1,   // det == 0, dot < 0, exactly 180
    CLS_HIGH = 2'd2,   // det > 0, angle in (180,360)
    CLS_FULL = 2'd3    // det == 0, dot >= 0, exactly 360
  } ang_cls_t;

  typedef struct packed {
    logic        [1:0]            opcode;
    logic        [NUM_PORTS-1:0]  connected_mask;
    logic        [PORT_W-1:0]     arrival_dir;
    logic signed [COORD_BITS-1:0] own_x;
    logic signed [COORD_BITS-1:0] own_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic        [PACK_W-1:0]     neighbour_xs;
    logic        [PACK_W-1:0]     neighbour_ys;
  } in_req_t;

  typedef struct packed {
    logic [PORT_W-1:0] chosen_port;
    logic              found;
  } out_res_t;

  // One lane's finding for a port
  typedef struct packed {
    logic                    has;
    logic [PORT_W-1:0]       idx;
    ang_cls_t                cls;
    logic signed [DOT_W-1:0] det;
    logic signed [DOT_W-1:0] dot;
  } cand_t;

  // Sideband that travels next to the lanes
  typedef struct packed {
    logic              found;
    logic              use_angle;
    logic [PORT_W-1:0] port;
  } side_t;

endpackage

// ----- rtl/hnrs_lane.sv -----
// ---------------------------------------------------------------------------
// hnrs_lane: per-port dot/cross product lane
// Forms the neighbour and target vectors around the own position, computes
// dot and det, classifies the angle and registers the candidate.
// ---------------------------------------------------------------------------
module hnrs_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                conn,
  input  logic [hnrs_pkg::PORT_W-1:0]         idx,
  input  logic signed [hnrs_pkg::COORD_BITS-1:0] own_x,
  input  logic signed [hnrs_pkg::COORD_BITS-1:0] own_y,
  input  logic signed [hnrs_pkg::COORD_BITS-1:0] target_x,
  input  logic signed [hnrs_pkg::COORD_BITS-1:0] target_y,
  input  logic signed [hnrs_pkg::COORD_BITS-1:0] nb_x,
  input  logic signed [hnrs_pkg::COORD_BITS-1:0] nb_y,
  output hnrs_pkg::cand_t                     cand_r
);
  import hnrs_pkg::*;

  logic signed [DIFF_W-1:0] vx1, vy1, vx2, vy2;
  logic signed [MUL_W-1:0]  pxx, pyy, pxy, pyx;
  logic signed [DOT_W-1:0]  dot_c, det_c;
  cand_t                    cand_nxt;

  // Vectors and products
  assign vx1 = DIFF_W'(nb_x) - DIFF_W'(own_x);
  assign vy1 = DIFF_W'(nb_y) - DIFF_W'(own_y);
  assign vx2 = DIFF_W'(target_x) - DIFF_W'(own_x);
  assign vy2 = DIFF_W'(target_y) - DIFF_W'(own_y);
  assign pxx = vx1 * vx2;
  assign pyy = vy1 * vy2;
  assign pxy = vx1 * vy2;
  assign pyx = vy1 * vx2;
  assign dot_c = DOT_W'(pxx) + DOT_W'(pyy);
  assign det_c = DOT_W'(pxy) - DOT_W'(pyx);

  // Classify the angle and build the candidate
  always_comb begin
    cand_nxt.has = conn;
    cand_nxt.idx = idx;
    cand_nxt.det = det_c;
    cand_nxt.dot = dot_c;
    priority if (det_c < 0) begin
      cand_nxt.cls = CLS_LOW;
    end else if (det_c > 0) begin
      cand_nxt.cls = CLS_HIGH;
    end else if (dot_c < 0) begin
      cand_nxt.cls = CLS_HALF;
    end else begin
      cand_nxt.cls = CLS_FULL;
    end
  end

  // Hold the candidate until the stage advances
  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand_nxt;
    end
  end

endmodule

// ----- rtl/hnrs_cmp.sv -----
// ---------------------------------------------------------------------------
// hnrs_cmp: merge node of the angle tournament
// Picks the candidate with the smaller angle; on a tie the lower port,
// which is always on the lo side, wins.
// ---------------------------------------------------------------------------
module hnrs_cmp (
  input  hnrs_pkg::cand_t lo,
  input  hnrs_pkg::cand_t hi,
  output hnrs_pkg::cand_t win
);
  import hnrs_pkg::*;

  logic signed [XPROD_W-1:0] prod_a, prod_b;
  logic                      same_open;
  logic                      take_hi;

  // Cross-multiplied compare: hi below lo when det_hi*dot_lo > dot_hi*det_lo
  assign prod_a = hi.det * lo.dot;
  assign prod_b = hi.dot * lo.det;

  assign same_open = (hi.cls == lo.cls) && ((hi.cls == CLS_LOW) || (hi.cls == CLS_HIGH));

  assign take_hi = hi.has &&
                   (!lo.has || (hi.cls < lo.cls) || (same_open && (prod_a > prod_b)));

  assign win = take_hi ? hi : lo;

endmodule

// ----- rtl/hex_neighbour_rotation_selector_core.sv -----
// ---------------------------------------------------------------------------
// hex_neighbour_rotation_selector_core: hexagonal port selector
// Picks one of six ports from a connection mask, by angle to a target or by
// rotating from the arrival port.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with an in_req struct; results leave
//   on out_valid/out_ready with an out_res struct, one result per request,
//   in request order.
//   Six lanes compute dot and cross products for all ports at once; a
//   two-level merge tree and the output stage pick the winner.
//   Path: a request passes the lane stage, two merge stages and the output
//   register before out_valid rises.
//   Throughput: one request per cycle while out_ready stays high; each stage
//   advances when it is empty or its successor advances, so bubbles collapse
//   and requests keep entering while a finished result waits.
//   When the receiver stalls, the pipeline fills and in_ready drops after
//   four requests are held.
//   Reset (rst_n low, synchronous) empties every stage; no result is pending
//   afterwards.
//   No connected port, or opcode 3, gives found = 0 and chosen_port = 0.
// ---------------------------------------------------------------------------
module hex_neighbour_rotation_selector_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hnrs_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output hnrs_pkg::out_res_t out_res
);
  import hnrs_pkg::*;

  // Stage valid bits and handshakes
  logic a_v_r, b_v_r, c_v_r, d_v_r;
  logic a_v_nxt, b_v_nxt, c_v_nxt, d_v_nxt;
  logic a_rdy, b_rdy, c_rdy, d_rdy;
  logic a_load, b_load, c_load, d_load;

  // Payload
  cand_t    a_cand [NUM_PORTS];
  cand_t    b_cand_r [3];
  cand_t    c_cand_r [2];
  cand_t    b_win [3];
  cand_t    c_win;
  cand_t    d_win;
  side_t    in_side, a_side_r, b_side_r, c_side_r;
  out_res_t d_res_r, d_res_nxt;

  // Rotation search
  logic [PORT_W-1:0] arr_w;
  logic [PORT_W-1:0] rot_port;
  logic [PORT_W:0]   rot_sum;
  logic [PORT_W-1:0] rot_p;
  logic              op_valid;

  // Ready chain
  assign d_rdy  = !d_v_r || out_ready;
  assign c_rdy  = !c_v_r || d_rdy;
  assign b_rdy  = !b_v_r || c_rdy;
  assign a_rdy  = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  assign a_load = in_valid && a_rdy;
  assign b_load = a_v_r && b_rdy;
  assign c_load = b_v_r && c_rdy;
  assign d_load = c_v_r && d_rdy;

  assign a_v_nxt = a_rdy ? in_valid : a_v_r;
  assign b_v_nxt = b_rdy ? a_v_r : b_v_r;
  assign c_v_nxt = c_rdy ? b_v_r : c_v_r;
  assign d_v_nxt = d_rdy ? c_v_r : d_v_r;

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      c_v_r <= c_v_nxt;
      d_v_r <= d_v_nxt;
    end
  end

  // Wrap the arrival port and find the next connected port in rotation
  always_comb begin
    arr_w    = (in_req.arrival_dir >= PORT_W'(NUM_PORTS)) ?
               in_req.arrival_dir - PORT_W'(NUM_PORTS) : in_req.arrival_dir;
    rot_port = '0;
    rot_sum  = '0;
    rot_p    = '0;
    // Walk from the farthest step down so the nearest hit is kept
    for (int k = NUM_PORTS; k >= 1; k--) begin
      if (in_req.opcode == OP_CCW) begin
        rot_sum = (PORT_W+1)'(arr_w) + (PORT_W+1)'(k);
      end else begin
        rot_sum = (PORT_W+1)'(arr_w) + (PORT_W+1)'(NUM_PORTS - k);
      end
      rot_p = (rot_sum >= (PORT_W+1)'(NUM_PORTS)) ?
              PORT_W'(rot_sum - (PORT_W+1)'(NUM_PORTS)) : PORT_W'(rot_sum);
      if (in_req.connected_mask[rot_p]) begin
        rot_port = rot_p;
      end
    end
  end

  // Sideband for the request
  always_comb begin
    op_valid = (in_req.opcode == OP_ANGLE) || (in_req.opcode == OP_CCW) ||
               (in_req.opcode == OP_CW);
    in_side.found     = op_valid && (in_req.connected_mask != '0);
    in_side.use_angle = (in_req.opcode == OP_ANGLE);
    in_side.port      = ((in_req.opcode == OP_CCW) || (in_req.opcode == OP_CW)) ?
                        rot_port : '0;
  end

  // Lanes: one per port
  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
    hnrs_lane u_lane (
      .clk      (clk),
      .en       (a_load),
      .conn     (in_req.connected_mask[g]),
      .idx      (PORT_W'(g)),
      .own_x    (in_req.own_x),
      .own_y    (in_req.own_y),
      .target_x (in_req.target_x),
      .target_y (in_req.target_y),
      .nb_x     ($signed(in_req.neighbour_xs[g*COORD_BITS +: COORD_BITS])),
      .nb_y     ($signed(in_req.neighbour_ys[g*COORD_BITS +: COORD_BITS])),
      .cand_r   (a_cand[g])
    );
  end

  // Hold sideband alongside the lanes
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_side_r <= in_side;
    end
  end

  // First merge level: pairs of ports
  for (genvar g = 0; g < 3; g++) begin : g_m1
    hnrs_cmp u_cmp (
      .lo  (a_cand[2*g]),
      .hi  (a_cand[2*g+1]),
      .win (b_win[g])
    );
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_cand_r <= b_win;
      b_side_r <= a_side_r;
    end
  end

  // Second merge level: ports 0-1 against 2-3, ports 4-5 pass along
  hnrs_cmp u_cmp_m2 (
    .lo  (b_cand_r[0]),
    .hi  (b_cand_r[1]),
    .win (c_win)
  );

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_cand_r[0] <= c_win;
      c_cand_r[1] <= b_cand_r[2];
      c_side_r    <= b_side_r;
    end
  end

  // Final merge and result select
  hnrs_cmp u_cmp_m3 (
    .lo  (c_cand_r[0]),
    .hi  (c_cand_r[1]),
    .win (d_win)
  );

  always_comb begin
    d_res_nxt.found = c_side_r.found;
    if (!c_side_r.found) begin
      d_res_nxt.chosen_port = '0;
    end else if (c_side_r.use_angle) begin
      d_res_nxt.chosen_port = d_win.idx;
    end else begin
      d_res_nxt.chosen_port = c_side_r.port;
    end
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      d_res_r <= d_res_nxt;
    end
  end

  assign out_valid = d_v_r;
  assign out_res   = d_res_r;

endmodule

// ----- verif/hnrs_result_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hnrs_result_checker: result predictor and scoreboard for the hex selector
// Watches both handshakes, predicts the port choice of every accepted
// request and compares each returned result with the oldest prediction.
// ---------------------------------------------------------------------------
module hnrs_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  hnrs_pkg::in_req_t  in_req,
  input  logic               out_valid,
  input  logic               out_ready,
  input  hnrs_pkg::out_res_t out_res,
  output int                 fail_count,
  output int                 pending
);
  import hnrs_pkg::*;

  out_res_t    expected_port_q[$];
  int unsigned results_seen = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Predict the port a request selects
  function automatic out_res_t pick_port(in_req_t req);
    out_res_t res;
    int       arr, p, k, best;
    longint   ox, oy, tdx, tdy, ndx, ndy, dot, det, bdot, bdet;
    ang_cls_t cls, bcls;
    logic     take;
    res  = '0;
    best = -1;
    bdot = 0;
    bdet = 0;
    bcls = CLS_LOW;
    if (req.connected_mask == '0) return res;
    case (req.opcode)
      OP_ANGLE: begin
        ox  = longint'($signed(req.own_x));
        oy  = longint'($signed(req.own_y));
        tdx = longint'($signed(req.target_x)) - ox;
        tdy = longint'($signed(req.target_y)) - oy;
        for (p = 0; p < NUM_PORTS; p++) begin
          if (req.connected_mask[p]) begin
            ndx = longint'($signed(req.neighbour_xs[p*COORD_BITS +: COORD_BITS])) - ox;
            ndy = longint'($signed(req.neighbour_ys[p*COORD_BITS +: COORD_BITS])) - oy;
            dot = ndx * tdx + ndy * tdy;
            det = ndx * tdy - ndy * tdx;
            // Order angles by angle class first
            if (det < 0)      cls = CLS_LOW;
            else if (det > 0) cls = CLS_HIGH;
            else if (dot < 0) cls = CLS_HALF;
            else              cls = CLS_FULL;
            // Within an open class compare by cross product; ties keep the lower port
            if (best < 0 || cls < bcls) take = 1'b1;
            else if (cls > bcls || cls == CLS_HALF || cls == CLS_FULL) take = 1'b0;
            else take = (det * bdot > dot * bdet);
            if (take) begin
              best = p;
              bcls = cls;
              bdet = det;
              bdot = dot;
            end
          end
        end
        res.found       = 1'b1;
        res.chosen_port = PORT_W'(best);
      end
      OP_CCW, OP_CW: begin
        // Arrival 6 and 7 wrap around; walk the ring farthest first so the
        // nearest connected port is the one left standing
        arr       = int'(req.arrival_dir) % NUM_PORTS;
        res.found = 1'b1;
        for (k = NUM_PORTS; k >= 1; k--) begin
          p = (req.opcode == OP_CCW) ? (arr + k) % NUM_PORTS
                                     : (arr + NUM_PORTS - k) % NUM_PORTS;
          if (req.connected_mask[p]) res.chosen_port = PORT_W'(p);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Compare results first, then queue the prediction for a new request
  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      expected_port_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_port_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending",
                                    results_seen));
        end else begin
          want = expected_port_q.pop_front();
          if (out_res.found !== want.found)
            report_mismatch($sformatf("result %0d found got %0b expected %0b",
                                      results_seen, out_res.found, want.found));
          if (out_res.chosen_port !== want.chosen_port)
            report_mismatch($sformatf("result %0d chosen_port got %0d expected %0d",
                                      results_seen, out_res.chosen_port,
                                      want.chosen_port));
        end
        results_seen++;
      end
      if (in_valid && in_ready) expected_port_q.push_back(pick_port(in_req));
    end
    pending <= expected_port_q.size();
  end

endmodule

// ----- verif/tb_hex_neighbour_rotation_selector_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hex_neighbour_rotation_selector_core: regression for the hex selector
// Sends directed corner requests, then random ones biased toward collinear
// and same-ray neighbours, with random gaps and result stalls on both sides.
// ---------------------------------------------------------------------------
module tb_hex_neighbour_rotation_selector_core;
  import hnrs_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RAND_REQS    = 650;
  localparam int         STALL_PCT    = 19;
  localparam int         QUIET_LIMIT  = 1000;
  localparam int         DRAIN_CYCLES = 12;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_res;
  logic     steady   = 1'b0;
  int       fail_count;
  int       pending;
  int       quiet_cycles = 0;

  always #2 clk = ~clk;

  hex_neighbour_rotation_selector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  hnrs_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the result side at random, except in the steady stretch
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("hex_neighbour_rotation_selector_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_req(input in_req_t req);
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic in_req_t mk_req(logic [1:0] op, logic [NUM_PORTS-1:0] mask,
                                     logic [PORT_W-1:0] arr, int ox, int oy,
                                     int tx, int ty);
    in_req_t r;
    r                = '0;
    r.opcode         = op;
    r.connected_mask = mask;
    r.arrival_dir    = arr;
    r.own_x          = COORD_BITS'(ox);
    r.own_y          = COORD_BITS'(oy);
    r.target_x       = COORD_BITS'(tx);
    r.target_y       = COORD_BITS'(ty);
    return r;
  endfunction

  // Place a neighbour of port p
  function automatic in_req_t place(in_req_t r, int p, int x, int y);
    r.neighbour_xs[p*COORD_BITS +: COORD_BITS] = COORD_BITS'(x);
    r.neighbour_ys[p*COORD_BITS +: COORD_BITS] = COORD_BITS'(y);
    return r;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  // Build a random request; most place neighbours on a few rays through the
  // own position so that collinear cases and equal-angle ties show up often
  function automatic in_req_t rand_req();
    in_req_t r;
    int      pick, ox, oy, dx, dy, rx, ry, k, p;
    int      px[NUM_PORTS];
    int      py[NUM_PORTS];
    r    = '0;
    pick = $urandom_range(0, 99);
    r.opcode = (pick < 50) ? OP_ANGLE : (pick < 72) ? OP_CCW :
               (pick < 94) ? OP_CW : OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 6)       r.connected_mask = '0;
    else if (pick < 20) r.connected_mask = NUM_PORTS'(1 << $urandom_range(0, NUM_PORTS - 1));
    else                r.connected_mask = NUM_PORTS'($urandom_range(0, 63));
    r.arrival_dir = PORT_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 40) begin
      r.own_x        = COORD_BITS'(rnd_coord());
      r.own_y        = COORD_BITS'(rnd_coord());
      r.target_x     = COORD_BITS'(rnd_coord());
      r.target_y     = COORD_BITS'(rnd_coord());
      r.neighbour_xs = PACK_W'({$urandom(), $urandom()});
      r.neighbour_ys = PACK_W'({$urandom(), $urandom()});
    end else begin
      ox = int'($urandom_range(0, 80)) - 40;
      oy = int'($urandom_range(0, 80)) - 40;
      dx = int'($urandom_range(0, 16)) - 8;
      dy = int'($urandom_range(0, 16)) - 8;
      rx = int'($urandom_range(0, 16)) - 8;
      ry = int'($urandom_range(0, 16)) - 8;
      k  = $urandom_range(0, 4);
      r.own_x    = COORD_BITS'(ox);
      r.own_y    = COORD_BITS'(oy);
      r.target_x = COORD_BITS'(ox + k * dx);
      r.target_y = COORD_BITS'(oy + k * dy);
      for (p = 0; p < NUM_PORTS; p++) begin
        k = $urandom_range(0, 4);
        case ($urandom_range(0, 4))
          0: begin px[p] = ox + k * dx;  py[p] = oy + k * dy; end
          1: begin px[p] = ox - k * dx;  py[p] = oy - k * dy; end
          2: begin px[p] = ox + k * rx;  py[p] = oy + k * ry; end
          3: begin
            px[p] = (p > 0) ? px[p-1] : ox;
            py[p] = (p > 0) ? py[p-1] : oy;
          end
          default: begin
            px[p] = ox + int'($urandom_range(0, 16)) - 8;
            py[p] = oy + int'($urandom_range(0, 16)) - 8;
          end
        endcase
        r = place(r, p, px[p], py[p]);
      end
    end
    return r;
  endfunction

  initial begin
    in_req_t r;
    int      n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // No port connected, and the unused opcode
    r = mk_req(OP_ANGLE, 6'h00, 3'd0, 0, 0, 10, 0);
    r = place(r, 0, 5, 5);
    send_req(r);
    send_req(mk_req(OP_UNUSED, 6'h3F, 3'd2, 1, 2, 3, 4));
    send_req(mk_req(OP_CCW, 6'h00, 3'd4, 0, 0, 0, 0));

    // Rotation: arrival wrap-around, lone arrival port, full ring
    send_req(mk_req(OP_CCW, 6'b000110, 3'd6, 0, 0, 0, 0));
    send_req(mk_req(OP_CW,  6'b100001, 3'd7, 0, 0, 0, 0));
    send_req(mk_req(OP_CCW, 6'b001000, 3'd3, 0, 0, 0, 0));
    send_req(mk_req(OP_CW,  6'b100000, 3'd5, 0, 0, 0, 0));
    send_req(mk_req(OP_CW,  6'h3F,     3'd0, 0, 0, 0, 0));
    send_req(mk_req(OP_CCW, 6'h3F,     3'd5, 0, 0, 0, 0));

    // Target on the own position: every angle is a full turn
    r = mk_req(OP_ANGLE, 6'h3F, 3'd0, 3, -4, 3, -4);
    r = place(r, 0, 5, -4);  r = place(r, 1, 4, -2);  r = place(r, 2, 2, -2);
    r = place(r, 3, 1, -4);  r = place(r, 4, 2, -6);  r = place(r, 5, 4, -6);
    send_req(r);

    // Zero vector, opposite ray and same ray as the target
    r = mk_req(OP_ANGLE, 6'b110100, 3'd0, 0, 0, 20, 10);
    r = place(r, 2, 0, 0);  r = place(r, 4, -4, -2);  r = place(r, 5, 8, 4);
    send_req(r);

    // Hexagonal ring around the own position
    r = mk_req(OP_ANGLE, 6'h3F, 3'd0, 0, 0, 10, 0);
    r = place(r, 0, 2, 0);   r = place(r, 1, 1, 2);   r = place(r, 2, -1, 2);
    r = place(r, 3, -2, 0);  r = place(r, 4, -1, -2); r = place(r, 5, 1, -2);
    send_req(r);
    r.target_x = COORD_BITS'(-3);
    r.target_y = COORD_BITS'(-7);
    send_req(r);

    // Equal angles: same ray at several distances, and duplicate neighbours
    r = mk_req(OP_ANGLE, 6'b001110, 3'd0, 0, 0, 5, 0);
    r = place(r, 1, 3, -3);  r = place(r, 2, 1, -1);  r = place(r, 3, 2, -2);
    send_req(r);
    r = mk_req(OP_ANGLE, 6'b101010, 3'd0, -10, 7, 30, -20);
    r = place(r, 1, -12, 20);  r = place(r, 3, -12, 20);  r = place(r, 5, 15, 0);
    send_req(r);

    // Coordinate extremes
    r = mk_req(OP_ANGLE, 6'h3F, 3'd0, -128, -128, 127, 127);
    r.neighbour_xs = 48'h7F807F807F80;
    r.neighbour_ys = 48'h80807F7F807F;
    send_req(r);
    r = mk_req(OP_ANGLE, 6'h3F, 3'd0, 127, 127, -128, -128);
    r.neighbour_xs = 48'h807F807F807F;
    r.neighbour_ys = 48'h7F7F80807F80;
    send_req(r);
    r = mk_req(OP_ANGLE, 6'h3F, 3'd0, 127, -128, -128, 127);
    r.neighbour_xs = 48'hFFFFFFFFFFFF;
    r.neighbour_ys = 48'h000000000000;
    send_req(r);
    r = mk_req(OP_ANGLE, 6'h3F, 3'd0, -128, 127, 127, -128);
    r.neighbour_xs = 48'h000000000000;
    r.neighbour_ys = 48'hFFFFFFFFFFFF;
    send_req(r);

    // Random requests, with a steady stretch free of gaps and stalls
    for (n = 0; n < RAND_REQS; n++) begin
      steady <= (n >= 250 && n < 380);
      send_req(rand_req());
    end
    steady   <= 1'b0;
    in_valid <= 1'b0;

    // Drain the pipeline, then hold for a few cycles to catch strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("hex_neighbour_rotation_selector_core regression: pass");
    end else begin
      $display("hex_neighbour_rotation_selector_core regression: fail");
    end
    $finish;
  end

endmodule
